// ===== rtl/olad_pkg.sv =====
// Package for the ordered list unit: widths, command and status codes,
// state encoding and the per-cell control struct.
// No dependencies.
package olad_pkg;

  localparam int unsigned DefDepth    = 16;
  localparam int unsigned DataW       = 32;
  localparam int unsigned EntryCountW = 5;

  typedef enum logic [1:0] {
    CmdAppend = 2'd0,
    CmdDelete = 2'd1,
    CmdDump   = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    StatAppended = 3'd0,
    StatDeleted  = 3'd1,
    StatNotFound = 3'd2,
    StatFull     = 3'd3,
    StatEmpty    = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DEL,
    ST_DUMP,
    ST_RESP
  } state_e;

  // Per-cell control: shift takes the neighbor's entry, load takes the write data.
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

endpackage

// ===== rtl/olad_req_if.sv =====
// Request channel of the ordered list unit: command and value.
// Depends on olad_pkg.
interface olad_req_if import olad_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               cmd;
  logic signed [DataW-1:0]  value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

// ===== rtl/olad_rsp_if.sv =====
// Result channel of the ordered list unit: status, element, count and last flag.
// Depends on olad_pkg.
interface olad_rsp_if import olad_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [2:0]               status;
  logic signed [DataW-1:0]  element;
  logic [EntryCountW-1:0]   entry_count;
  logic                     last;

  modport source (output valid, output status, output element, output entry_count,
                  output last, input ready);
  modport sink   (input valid, input status, input element, input entry_count,
                  input last, output ready);
endinterface

// ===== rtl/olad_cell.sv =====
// One list cell: holds a single entry and can take its right neighbor's entry
// or the broadcast write data. Depends on olad_pkg.
module olad_cell import olad_pkg::*; (
  input  logic             clk_i,
  input  cell_ctl_t        ctl_i,
  input  logic [DataW-1:0] nxt_i,
  input  logic [DataW-1:0] wr_data_i,
  output logic [DataW-1:0] data_o
);

  logic [DataW-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (ctl_i.load) begin
      data_d = wr_data_i;
    end else if (ctl_i.shift) begin
      data_d = nxt_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ===== rtl/ordered_list_append_delete_unit.sv =====
// Ordered list unit: a chain of cells, head at cell 0, with an output register.
// Append, a full drop, and delete or dump on an empty list finish in ST_IDLE;
// the result goes to the output register, or waits in ST_RESP while it is busy.
// Cmd 3 is accepted but gives no result. Delete rotates the chain once; dump
// rotates it too, one entry per cycle while the sink takes them. Reset empties the list.
module ordered_list_append_delete_unit import olad_pkg::*; #(
  parameter int unsigned DEPTH = DefDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  olad_req_if.sink      req_i,
  olad_rsp_if.source    rsp_o
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [DataW-1:0] cell_data [DEPTH];
  cell_ctl_t        cell_ctl  [DEPTH];

  state_e           st_q, st_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [IW-1:0]    step_q, step_d;
  logic [IW-1:0]    wrap_q, wrap_d;
  logic             found_q, found_d;
  logic [DataW-1:0] val_q, val_d;
  status_e          pend_q, pend_d;

  logic                   rsp_vld_q, rsp_vld_d;
  logic [2:0]             rsp_status_q;
  logic [DataW-1:0]       rsp_elem_q;
  logic [EntryCountW-1:0] rsp_cnt_q;
  logic                   rsp_last_q;

  logic             accept, can_emit, drop, at_last;
  logic [IW-1:0]    last_idx;
  logic [DataW-1:0] head;

  logic             shift_en, wr_en;
  logic [IW-1:0]    wr_pos;
  logic [DataW-1:0] wr_data;

  logic             res_vld, res_last;
  status_e          res_status;
  logic [DataW-1:0] res_elem;

  // The cell chain.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DataW-1:0] nxt;
    if (g == DEPTH - 1) begin : g_tail
      assign nxt = '0;
    end else begin : g_body
      assign nxt = cell_data[g+1];
    end
    assign cell_ctl[g].shift = shift_en;
    assign cell_ctl[g].load  = wr_en && (wr_pos == IW'(g));
    olad_cell u_cell (
      .clk_i     (clk_i),
      .ctl_i     (cell_ctl[g]),
      .nxt_i     (nxt),
      .wr_data_i (wr_data),
      .data_o    (cell_data[g])
    );
  end

  assign head      = cell_data[0];
  assign accept    = req_i.valid && req_i.ready;
  assign can_emit  = !rsp_vld_q || rsp_o.ready;
  assign last_idx  = IW'(cnt_q - CW'(1));
  assign at_last   = (step_q == last_idx);
  assign req_i.ready = (st_q == ST_IDLE);

  always_comb begin
    st_d       = st_q;
    cnt_d      = cnt_q;
    step_d     = step_q;
    wrap_d     = wrap_q;
    found_d    = found_q;
    val_d      = val_q;
    pend_d     = pend_q;
    shift_en   = 1'b0;
    wr_en      = 1'b0;
    wr_pos     = wrap_q;
    wr_data    = head;
    drop       = 1'b0;
    res_vld    = 1'b0;
    res_status = StatAppended;
    res_elem   = '0;
    res_last   = 1'b1;

    unique case (st_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd_e'(req_i.cmd))
            CmdAppend: begin
              res_vld = 1'b1;
              if (cnt_q < CW'(DEPTH)) begin
                wr_en      = 1'b1;
                wr_pos     = cnt_q[IW-1:0];
                wr_data    = req_i.value;
                cnt_d      = cnt_q + CW'(1);
                res_status = StatAppended;
              end else begin
                res_status = StatFull;
              end
            end
            CmdDelete: begin
              if (cnt_q == '0) begin
                res_vld    = 1'b1;
                res_status = StatNotFound;
              end else begin
                st_d    = ST_DEL;
                step_d  = '0;
                wrap_d  = last_idx;
                found_d = 1'b0;
                val_d   = req_i.value;
              end
            end
            CmdDump: begin
              if (cnt_q == '0) begin
                res_vld    = 1'b1;
                res_status = StatEmpty;
              end else begin
                st_d   = ST_DUMP;
                step_d = '0;
                wrap_d = last_idx;
              end
            end
            default: ;
          endcase
        end
      end
      ST_DEL: begin
        // The head leaves the chain each cycle; it goes back in at the tail
        // unless it is the first entry equal to the value.
        shift_en = 1'b1;
        drop     = !found_q && (head == val_q);
        wr_en    = !drop;
        step_d   = step_q + IW'(1);
        if (drop) begin
          found_d = 1'b1;
          wrap_d  = wrap_q - IW'(1);
        end
        if (at_last) begin
          res_vld    = 1'b1;
          res_status = (found_q || drop) ? StatDeleted : StatNotFound;
          pend_d     = res_status;
          if (found_q || drop) begin
            cnt_d = cnt_q - CW'(1);
          end
          st_d = can_emit ? ST_IDLE : ST_RESP;
        end
      end
      ST_DUMP: begin
        if (can_emit) begin
          shift_en   = 1'b1;
          wr_en      = 1'b1;
          res_vld    = 1'b1;
          res_status = StatAppended;
          res_elem   = head;
          res_last   = at_last;
          step_d     = step_q + IW'(1);
          if (at_last) begin
            st_d = ST_IDLE;
          end
        end
      end
      ST_RESP: begin
        if (can_emit) begin
          res_vld    = 1'b1;
          res_status = pend_q;
          st_d       = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase

    // A single-result request that finds the output register busy waits here.
    if (st_q == ST_IDLE && res_vld && !can_emit) begin
      pend_d = res_status;
      st_d   = ST_RESP;
    end
  end

  always_comb begin
    rsp_vld_d = rsp_vld_q && !rsp_o.ready;
    if (res_vld && can_emit) begin
      rsp_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      cnt_q     <= '0;
      step_q    <= '0;
      wrap_q    <= '0;
      found_q   <= 1'b0;
      pend_q    <= StatAppended;
      rsp_vld_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      cnt_q     <= cnt_d;
      step_q    <= step_d;
      wrap_q    <= wrap_d;
      found_q   <= found_d;
      pend_q    <= pend_d;
      rsp_vld_q <= rsp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    if (res_vld && can_emit) begin
      rsp_status_q <= res_status;
      rsp_elem_q   <= res_elem;
      rsp_cnt_q    <= EntryCountW'(cnt_d);
      rsp_last_q   <= res_last;
    end
  end

  assign rsp_o.valid       = rsp_vld_q;
  assign rsp_o.status      = rsp_status_q;
  assign rsp_o.element     = rsp_elem_q;
  assign rsp_o.entry_count = rsp_cnt_q;
  assign rsp_o.last        = rsp_last_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("entry count exceeds depth");

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_DEL || st_q == ST_DUMP) |-> step_q <= last_idx)
    else $error("rotation step beyond last entry");

  a_dump_keeps_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_DUMP) |=> cnt_q == $past(cnt_q))
    else $error("dump changed the entry count");

  a_dump_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_DUMP && can_emit && at_last) |=> st_q == ST_IDLE)
    else $error("dump did not finish after the last entry");

  a_resp_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_RESP) |-> rsp_vld_q)
    else $error("pending result held while output register is free");

endmodule
